// ----- src/stip_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the string-to-integer parser.
// No dependencies; every other file imports this package.
package stip_pkg;

    localparam int VALUE_W = 64;
    localparam int COUNT_W = 13;
    localparam int BASE_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W = 8;

    localparam logic [BASE_W-1:0] NUMBER_BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] DEFAULT_RADIX = 6'd10;

    localparam int MAX_STRING_LEN_DEFAULT = 4096;
    localparam int COUNT_FIELD_MAX = 8191;

    localparam int QUEUE_DEPTH = 4;

    // Byte class as seen by the front end; the back end applies the phase.
    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_MINUS,
        CLS_PLUS,
        CLS_DIGIT,
        CLS_STOP
    } char_class_t;

    typedef struct packed {
        char_class_t              cls;
        logic [DIGIT_W-1:0]       digit;
        logic                     last;
    } queue_entry_t;

endpackage

// ----- src/stip_if.sv -----
`timescale 1ns / 1ps
// Stream interfaces of the parser: the byte channel and the result channel.
// Depends on stip_pkg for field widths.
interface stip_char_if
    import stip_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

interface stip_result_if
    import stip_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [COUNT_W-1:0]        stop_offset;
    logic                      digits_found;

    modport source (output valid, output value, output stop_offset, output digits_found,
                    input ready);
    modport sink (input valid, input value, input stop_offset, input digits_found,
                  output ready);
endinterface

// ----- src/stip_front.sv -----
`timescale 1ns / 1ps
// Front end: holds the radix register, accepts bytes and classifies them.
// Depends on stip_pkg and stip_char_if.
module stip_front
    import stip_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    stip_char_if.sink          text,
    input  logic               cfg_we,
    input  logic [BASE_W-1:0]  cfg_data,
    input  logic               queue_full,
    output logic               push,
    output queue_entry_t       push_entry,
    output logic [BASE_W-1:0]  radix
);

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ    = 8'h5a;
    localparam logic [CHAR_W-1:0] ALPHA_BIAS = 8'd10;

    logic [BASE_W-1:0]  base_reg;
    logic [CHAR_W-1:0]  c;
    logic [CHAR_W-1:0]  dval;
    logic               is_digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= NUMBER_BASE_RESET;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_data;
        end
    end

    assign radix = (base_reg == '0) ? DEFAULT_RADIX : base_reg;

    assign c = text.character;

    always_comb
    begin
        is_digit = 1'b1;
        dval = '0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            dval = c - CHAR_0;
        end
        else if (c >= CHAR_LA && c <= CHAR_LZ)
        begin
            dval = c - CHAR_LA + ALPHA_BIAS;
        end
        else if (c >= CHAR_UA && c <= CHAR_UZ)
        begin
            dval = c - CHAR_UA + ALPHA_BIAS;
        end
        else
        begin
            is_digit = 1'b0;
        end
    end

    always_comb
    begin
        push_entry.digit = dval[DIGIT_W-1:0];
        push_entry.last = text.last;
        if (c == CHAR_SPACE || c == CHAR_TAB)
        begin
            push_entry.cls = CLS_SPACE;
        end
        else if (c == CHAR_MINUS)
        begin
            push_entry.cls = CLS_MINUS;
        end
        else if (c == CHAR_PLUS)
        begin
            push_entry.cls = CLS_PLUS;
        end
        else if (is_digit && (dval[DIGIT_W-1:0] < radix))
        begin
            push_entry.cls = CLS_DIGIT;
        end
        else
        begin
            // NUL, other non-digit bytes and digits not below the radix land here
            push_entry.cls = CLS_STOP;
        end
    end

    assign text.ready = !queue_full;
    assign push = text.valid && !queue_full;

endmodule

// ----- src/stip_queue.sv -----
`timescale 1ns / 1ps
// Small word queue between the classifier and the accumulator.
// Depends on stip_pkg for the entry type and depth.
module stip_queue
    import stip_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  queue_entry_t  push_entry,
    input  logic          pop,
    output queue_entry_t  head,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    queue_entry_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head = mem[rd_ptr_reg];
    assign full = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);

endmodule

// ----- src/stip_back.sv -----
`timescale 1ns / 1ps
// Back end: parse phase, multiply-accumulate and the result register.
// Depends on stip_pkg and stip_result_if.
module stip_back
    import stip_pkg::*;
#(
    parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  queue_entry_t       head,
    input  logic [BASE_W-1:0]  radix,
    output logic               pop,
    stip_result_if.source      result
);

    localparam int COUNT_LIMIT =
        (MAX_STRING_LEN < COUNT_FIELD_MAX) ? MAX_STRING_LEN : COUNT_FIELD_MAX;
    localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(COUNT_LIMIT);

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_DIGITS,
        PH_STOPPED
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  acc_reg, acc_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                any_reg, any_next;

    logic                res_valid_reg, res_valid_next;
    logic                res_neg_reg;
    logic [VALUE_W-1:0]  res_acc_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic                res_any_reg;

    logic [VALUE_W-1:0]  mac;
    logic [COUNT_W-1:0]  count_inc;

    // a last word may only move on when the result register is free
    assign pop = !empty && (!head.last || !res_valid_reg || result.ready);

    assign mac = acc_reg * VALUE_W'(radix) + VALUE_W'(head.digit);
    assign count_inc = (count_reg < LIMIT) ? count_reg + 1'b1 : count_reg;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        count_next = count_reg;
        any_next = any_reg;
        if (pop)
        begin
            unique case (phase_reg)
                PH_SPACE:
                begin
                    case (head.cls)
                        CLS_SPACE:
                        begin
                            count_next = count_inc;
                        end
                        CLS_MINUS:
                        begin
                            neg_next = 1'b1;
                            count_next = count_inc;
                            phase_next = PH_DIGITS;
                        end
                        CLS_PLUS:
                        begin
                            count_next = count_inc;
                            phase_next = PH_DIGITS;
                        end
                        CLS_DIGIT:
                        begin
                            acc_next = mac;
                            any_next = 1'b1;
                            count_next = count_inc;
                            phase_next = PH_DIGITS;
                        end
                        default:
                        begin
                            phase_next = PH_STOPPED;
                        end
                    endcase
                end
                PH_DIGITS:
                begin
                    if (head.cls == CLS_DIGIT)
                    begin
                        acc_next = mac;
                        any_next = 1'b1;
                        count_next = count_inc;
                    end
                    else
                    begin
                        phase_next = PH_STOPPED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop && head.last)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg <= 1'b0;
            acc_reg <= '0;
            count_reg <= '0;
            any_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop && head.last)
            begin
                // string done: clear parse state for the next one
                phase_reg <= PH_SPACE;
                neg_reg <= 1'b0;
                acc_reg <= '0;
                count_reg <= '0;
                any_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg <= neg_next;
                acc_reg <= acc_next;
                count_reg <= count_next;
                any_reg <= any_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            res_neg_reg <= neg_next;
            res_acc_reg <= acc_next;
            res_count_reg <= count_next;
            res_any_reg <= any_next;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.value = res_neg_reg ? -$signed(res_acc_reg) : $signed(res_acc_reg);
    assign result.stop_offset = res_count_reg;
    assign result.digits_found = res_any_reg;

endmodule

// ----- src/string_to_integer_parser.sv -----
`timescale 1ns / 1ps
// Flow: an accepted word enters the queue and its pop loads the accumulator; for a last
//   word the result register loads on that pop instead, once that register is free.
// Throughput: one word per cycle (one multiply-accumulate each) unless a last word stalls.
// Reset: radix returns to ten, the four-word queue empties, parse state clears.
// Depends on stip_pkg, stip_if, stip_front, stip_queue and stip_back.
module string_to_integer_parser
    import stip_pkg::*;
#(
    parameter int MAX_STRING_LEN = MAX_STRING_LEN_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    stip_char_if.sink          text,
    stip_result_if.source      result,
    input  logic               cfg_we,
    input  logic [BASE_W-1:0]  cfg_data
);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    queue_entry_t       push_entry;
    queue_entry_t       head;
    logic [BASE_W-1:0]  radix;

    stip_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry),
        .radix      (radix)
    );

    stip_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    stip_back #(
        .MAX_STRING_LEN (MAX_STRING_LEN)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .radix  (radix),
        .pop    (pop),
        .result (result)
    );

endmodule
